// ----- hdl/swr_pkg.sv -----
// Shared types, constants and codes for the sliding window receiver.
// Used by swr_rem, swr_dp, swr_ctrl and sliding_window_receiver.
package swr_pkg;

    localparam int SEQ_W     = 16;
    localparam int WC_W      = 8;
    localparam int TOT_W     = 8;
    localparam int LEN_W     = 11;
    localparam int SLOT_W    = 6;
    localparam int KIND_W    = 2;
    localparam int REM_CNT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam int MAX_WINDOW = 63;

    typedef logic [SEQ_W-1:0]     seq_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [REM_CNT_W-1:0] rem_cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [KIND_W-1:0]    kind_t;

    localparam len_t     MAX_PAYLOAD = 11'd1468;
    localparam slot_t    WS_RESET    = 6'd35;
    localparam seq_t     SP_RESET    = 16'd340;
    localparam seq_t     SP_MIN      = 16'd2;
    localparam rem_cnt_t REM_STEPS   = 5'd16;

    // register indexes
    localparam cfg_idx_t CFG_WINDOW_SIZE = 1'b0;
    localparam cfg_idx_t CFG_SEQ_SPACE   = 1'b1;

    // result kinds
    localparam kind_t KIND_VERDICT = 2'd0;
    localparam kind_t KIND_RELEASE = 2'd1;
    localparam kind_t KIND_ACK     = 2'd2;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_num;
        logic [WC_W-1:0]  window_count;
        logic [TOT_W-1:0] total_expected;
        logic [LEN_W-1:0] payload_len;
    } hdr_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  length;
        logic [SEQ_W-1:0]  ack_seq;
        logic              finished;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_VERDICT,
        EMIT_RELEASE,
        EMIT_ACK,
        EMIT_DROP
    } emit_t;

    // controller -> datapath
    typedef struct packed {
        logic  load;
        logic  rem_seq;
        logic  rem_base;
        logic  save_rseq;
        logic  calc_off;
        logic  update;
        logic  cnt_clear;
        logic  cnt_inc;
        emit_t emit;
        logic  finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic halted;
        logic rem_done;
        logic full;
        logic out_free;
        logic cnt_last;
    } status_t;

endpackage

// ----- hdl/sliding_window_receiver.sv -----
// Top level of the selective-repeat receive window.
// Depends on swr_pkg, swr_ctrl and swr_dp.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  hdr      | hdr_valid / hdr_stall | swr_pkg::hdr_t, one packet header
//  res      | res_valid / res_stall | swr_pkg::res_t, verdict/release/ack
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (window, seq space)
//
// A header's first result comes out after these steps in order: the offset needs
// two 16-bit remainders (seq and base modulo the space), run one after the other
// on a single bit-serial remainder unit of 16 steps each, then the offset, update
// and decide states. A release run then reads each slot through the registered
// length memory and loads it into the output register, then the acknowledgement.
// A halted block puts out its dropped verdict from the drop state after taking
// the header. No clearing pass after reset; the length memory is only read
// for slots marked present. res_stall holds results in the output register and
// stalls the controller while a new item waits; the next header is taken once
// the previous item's last result is loaded into the output register.
module sliding_window_receiver (
    input  logic                      clk,
    input  logic                      rst_n,
    // packet headers
    input  logic                      hdr_valid,
    output logic                      hdr_stall,
    input  swr_pkg::hdr_t             hdr,
    // results
    output logic                      res_valid,
    input  logic                      res_stall,
    output swr_pkg::res_t             res,
    // register writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  swr_pkg::cfg_idx_t         cfg_index,
    input  logic [swr_pkg::CFG_W-1:0] cfg_data
);

    swr_pkg::cmd_t    cmd;
    swr_pkg::status_t status;

    // registers are always writable; the user must write them only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    swr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .status    (status),
        .cmd       (cmd)
    );

    swr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hdr       (hdr),
        .res_stall (res_stall),
        .res       (res),
        .res_valid (res_valid),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hdl/swr_rem.sv -----
// Iterative 16-bit remainder unit, one quotient bit per cycle.
// Depends on swr_pkg.
module swr_rem (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  swr_pkg::seq_t dividend,
    input  swr_pkg::seq_t divisor,
    output logic          done,
    output swr_pkg::seq_t rem
);

    swr_pkg::seq_t     rem_reg;
    swr_pkg::seq_t     dvd_reg;
    swr_pkg::seq_t     div_reg;
    swr_pkg::rem_cnt_t cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [swr_pkg::SEQ_W:0] trial;
    logic [swr_pkg::SEQ_W:0] diff;
    logic                    ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[swr_pkg::SEQ_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= swr_pkg::REM_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == swr_pkg::rem_cnt_t'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[swr_pkg::SEQ_W-1:0] : trial[swr_pkg::SEQ_W-1:0];
            dvd_reg <= {dvd_reg[swr_pkg::SEQ_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/swr_dp.sv -----
// Datapath: config registers, window state, length memory, result register.
// Depends on swr_pkg and swr_rem.
module swr_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  swr_pkg::cfg_idx_t cfg_index,
    input  logic [swr_pkg::CFG_W-1:0] cfg_data,
    input  swr_pkg::hdr_t     hdr,
    input  logic              res_stall,
    output swr_pkg::res_t     res,
    output logic              res_valid,
    input  swr_pkg::cmd_t     cmd,
    output swr_pkg::status_t  status
);

    // config
    swr_pkg::slot_t ws_reg;
    swr_pkg::seq_t  sp_reg;
    swr_pkg::slot_t ws_eff;
    swr_pkg::seq_t  sp_eff;

    // window state
    swr_pkg::seq_t                   base_reg;
    logic [swr_pkg::MAX_WINDOW-1:0]  mask_reg;
    swr_pkg::seq_t                   total_reg;
    logic                            complete_reg;
    logic                            halted_reg;
    swr_pkg::len_t                   len_mem [swr_pkg::MAX_WINDOW];
    swr_pkg::len_t                   rd_data_reg;

    // per item
    swr_pkg::seq_t                   rseq_reg;
    swr_pkg::seq_t                   off_reg;
    swr_pkg::slot_t                  wc_reg;
    logic [swr_pkg::TOT_W-1:0]       tot_reg;
    swr_pkg::len_t                   plen_reg;
    logic                            acc_reg;
    swr_pkg::slot_t                  slot_reg;
    swr_pkg::slot_t                  cnt_reg;

    // result
    swr_pkg::res_t                   res_reg;
    swr_pkg::res_t                   res_next;
    logic                            res_valid_reg;

    // remainder unit
    logic          rem_start;
    swr_pkg::seq_t rem_dividend;
    logic          rem_done;
    swr_pkg::seq_t rem_out;

    swr_pkg::slot_t                  wc_clamp;
    logic [swr_pkg::SEQ_W:0]         off_sum;
    logic [swr_pkg::SEQ_W:0]         off_red;
    logic                            in_win;
    logic                            hit;
    swr_pkg::seq_t                   total_next;
    logic [swr_pkg::MAX_WINDOW-1:0]  need;
    logic [swr_pkg::SEQ_W:0]         base_sum;

    always_comb
    begin
        if (ws_reg == '0)
            ws_eff = swr_pkg::slot_t'(1);
        else if (32'(ws_reg) > swr_pkg::MAX_WINDOW)
            ws_eff = swr_pkg::slot_t'(swr_pkg::MAX_WINDOW);
        else
            ws_eff = ws_reg;
        sp_eff = (sp_reg < swr_pkg::SP_MIN) ? swr_pkg::SP_MIN : sp_reg;
    end

    always_comb
    begin
        if (hdr.window_count > {2'b00, ws_eff})
            wc_clamp = ws_eff;
        else if (hdr.window_count == '0)
            wc_clamp = swr_pkg::slot_t'(1);
        else
            wc_clamp = hdr.window_count[swr_pkg::SLOT_W-1:0];
    end

    assign rem_start    = cmd.rem_seq | cmd.rem_base;
    assign rem_dividend = cmd.rem_seq ? hdr.seq_num : base_reg;

    swr_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (sp_eff),
        .done     (rem_done),
        .rem      (rem_out)
    );

    // (seq mod sp) + sp - (base mod sp), then one conditional subtract
    always_comb
    begin
        off_sum = {1'b0, rseq_reg} + {1'b0, sp_eff} - {1'b0, rem_out};
        off_red = (off_sum >= {1'b0, sp_eff}) ? off_sum - {1'b0, sp_eff} : off_sum;
    end

    always_comb
    begin
        in_win = (off_reg < swr_pkg::seq_t'(wc_reg));
        hit    = in_win && !mask_reg[off_reg[swr_pkg::SLOT_W-1:0]];
        total_next = (hit && (total_reg != '1)) ? total_reg + 1'b1 : total_reg;
    end

    always_comb
    begin
        for (int j = 0; j < swr_pkg::MAX_WINDOW; j++)
        begin
            need[j] = (swr_pkg::slot_t'(j) < wc_reg);
        end
    end

    assign base_sum = {1'b0, base_reg} + {{(swr_pkg::SEQ_W + 1 - swr_pkg::SLOT_W){1'b0}}, ws_eff};

    always_comb
    begin
        res_next = '0;
        unique case (cmd.emit)
            swr_pkg::EMIT_VERDICT:
            begin
                res_next.kind     = swr_pkg::KIND_VERDICT;
                res_next.accepted = acc_reg;
                res_next.slot     = slot_reg;
                res_next.last     = 1'b1;
            end
            swr_pkg::EMIT_RELEASE:
            begin
                res_next.kind   = swr_pkg::KIND_RELEASE;
                res_next.slot   = cnt_reg;
                res_next.length = rd_data_reg;
            end
            swr_pkg::EMIT_ACK:
            begin
                res_next.kind     = swr_pkg::KIND_ACK;
                res_next.accepted = acc_reg;
                res_next.slot     = slot_reg;
                res_next.ack_seq  = base_reg + swr_pkg::seq_t'(wc_reg) - 1'b1;
                res_next.finished = complete_reg;
                res_next.last     = 1'b1;
            end
            swr_pkg::EMIT_DROP:
            begin
                res_next.kind = swr_pkg::KIND_VERDICT;
                res_next.last = 1'b1;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= swr_pkg::WS_RESET;
            sp_reg        <= swr_pkg::SP_RESET;
            base_reg      <= '0;
            mask_reg      <= '0;
            total_reg     <= '0;
            complete_reg  <= 1'b0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    swr_pkg::CFG_WINDOW_SIZE: ws_reg <= cfg_data[swr_pkg::SLOT_W-1:0];
                    swr_pkg::CFG_SEQ_SPACE:   sp_reg <= cfg_data[swr_pkg::SEQ_W-1:0];
                endcase
            end

            if (cmd.update)
            begin
                if (hit)
                    mask_reg[off_reg[swr_pkg::SLOT_W-1:0]] <= 1'b1;
                total_reg <= total_next;
                if (total_next == swr_pkg::seq_t'(tot_reg))
                    complete_reg <= 1'b1;
            end

            if (cmd.finish)
            begin
                if (complete_reg)
                    halted_reg <= 1'b1;
                else
                begin
                    base_reg <= (base_sum >= {1'b0, sp_eff}) ? '0
                                                             : base_sum[swr_pkg::SEQ_W-1:0];
                    mask_reg <= '0;
                end
            end

            if (cmd.emit != swr_pkg::EMIT_NONE)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wc_reg   <= wc_clamp;
            tot_reg  <= hdr.total_expected;
            plen_reg <= (hdr.payload_len > swr_pkg::MAX_PAYLOAD) ? swr_pkg::MAX_PAYLOAD
                                                                 : hdr.payload_len;
        end
        if (cmd.save_rseq)
            rseq_reg <= rem_out;
        if (cmd.calc_off)
            off_reg <= off_red[swr_pkg::SEQ_W-1:0];
        if (cmd.update)
        begin
            acc_reg  <= hit;
            slot_reg <= in_win ? off_reg[swr_pkg::SLOT_W-1:0] : '0;
        end
        if (cmd.cnt_clear)
            cnt_reg <= '0;
        else if (cmd.cnt_inc)
            cnt_reg <= cnt_reg + 1'b1;
        if (cmd.emit != swr_pkg::EMIT_NONE)
            res_reg <= res_next;
    end

    // slot length memory
    always_ff @(posedge clk)
    begin
        if (cmd.update && hit)
            len_mem[off_reg[swr_pkg::SLOT_W-1:0]] <= plen_reg;
        rd_data_reg <= len_mem[cnt_reg];
    end

    always_comb
    begin
        status.halted   = halted_reg;
        status.rem_done = rem_done;
        status.full     = &(mask_reg | ~need);
        status.out_free = !res_valid_reg || !res_stall;
        status.cnt_last = (cnt_reg == wc_reg - 1'b1);
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// ----- hdl/swr_ctrl.sv -----
// Controller: sequences remainder, update, verdict, release run, acknowledgement and drop.
// Depends on swr_pkg.
module swr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             hdr_valid,
    output logic             hdr_stall,
    input  swr_pkg::status_t status,
    output swr_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_SEQ,
        ST_MOD_BASE,
        ST_OFFSET,
        ST_UPDATE,
        ST_DECIDE,
        ST_REL_RD,
        ST_REL_OUT,
        ST_ACK,
        ST_DROP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = swr_pkg::EMIT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (hdr_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.halted)
                        state_next = ST_DROP;
                    else
                    begin
                        cmd.rem_seq = 1'b1;
                        state_next  = ST_MOD_SEQ;
                    end
                end
            end
            ST_MOD_SEQ:
            begin
                if (status.rem_done)
                begin
                    cmd.save_rseq = 1'b1;
                    cmd.rem_base  = 1'b1;
                    state_next    = ST_MOD_BASE;
                end
            end
            ST_MOD_BASE:
            begin
                if (status.rem_done)
                    state_next = ST_OFFSET;
            end
            ST_OFFSET:
            begin
                cmd.calc_off = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.cnt_clear = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.full)
                    state_next = ST_REL_RD;
                else if (status.out_free)
                begin
                    cmd.emit   = swr_pkg::EMIT_VERDICT;
                    state_next = ST_IDLE;
                end
            end
            ST_REL_RD:
            begin
                state_next = ST_REL_OUT;
            end
            ST_REL_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = swr_pkg::EMIT_RELEASE;
                    if (status.cnt_last)
                        state_next = ST_ACK;
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_REL_RD;
                    end
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = swr_pkg::EMIT_ACK;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DROP:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = swr_pkg::EMIT_DROP;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign hdr_stall = (state_reg != ST_IDLE);

endmodule

// ----- verif/sliding_window_receiver_tb.sv -----
// Self-checking testbench for sliding_window_receiver: drives packet headers and register
// writes, predicts every verdict, release and acknowledgement item and compares them.
// Depends on swr_pkg and the sliding_window_receiver RTL.
module sliding_window_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest quiet stretch: the header latency, the result stall, a sender
    // gap and the settle waits; taken well over ten times.
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    // Accepted count must stay small enough that a total_expected (8 bits)
    // can still match it in the final completion test.
    localparam int STORE_CAP     = 215;
    localparam int STORE_STOP    = 190;
    localparam int PHASE_ITEMS   = 36;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      hdr_valid = 1'b0;
    logic                      hdr_stall;
    swr_pkg::hdr_t             hdr_bus   = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    swr_pkg::res_t             res_bus;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    swr_pkg::cfg_idx_t         cfg_index = swr_pkg::CFG_WINDOW_SIZE;
    logic [swr_pkg::CFG_W-1:0] cfg_data  = '0;

    // Receive window as the testbench sees it
    logic [5:0]    ws_cfg       = swr_pkg::WS_RESET;
    swr_pkg::seq_t space_cfg    = swr_pkg::SP_RESET;
    int unsigned   base_seq     = 0;
    logic [63:0]   slot_present = '0;
    swr_pkg::len_t slot_len [64];
    int unsigned   stored_total = 0;
    bit            xfer_done    = 1'b0;
    bit            rx_halted    = 1'b0;
    int unsigned   windows_slid = 0;

    // Items still owed by the block, oldest first
    swr_pkg::res_t due_events [$];
    swr_pkg::res_t next_due;

    bit          finish_allowed = 1'b0;
    int unsigned headers_sent   = 0;
    int unsigned mismatches     = 0;
    int unsigned burst_left     = 1;
    int unsigned quiet_cycles   = 0;
    logic [6:0]  stall_step     = '0;
    rx_mode_t    stall_mode     = RX_FREE;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr       (hdr_bus),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_bus),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned effective_window();
        int unsigned ws;
        ws = (ws_cfg == 6'd0) ? 1 : ws_cfg;
        if (ws > swr_pkg::MAX_WINDOW)
            ws = swr_pkg::MAX_WINDOW;
        return ws;
    endfunction

    function automatic int unsigned effective_space();
        return (space_cfg < swr_pkg::SP_MIN) ? swr_pkg::SP_MIN : space_cfg;
    endfunction

    // Offset of a header from the window base and whether it lands in a free slot
    task automatic locate(input swr_pkg::hdr_t h, output int unsigned ws,
                          output int unsigned sp, output int unsigned wc,
                          output int unsigned off, output bit fits);
        ws = effective_window();
        sp = effective_space();
        wc = h.window_count;
        if (wc > ws)
            wc = ws;
        if (wc == 0)
            wc = 1;
        // base may sit beyond a space that was shrunk, so reduce it too
        off = ((h.seq_num % sp) + sp - (base_seq % sp)) % sp;
        fits = 1'b0;
        if (!rx_halted && off < wc)
            fits = !slot_present[off];
    endtask

    // Works out the items one accepted header causes and updates the window
    task automatic judge_header(input swr_pkg::hdr_t h);
        int unsigned   ws, sp, wc, off;
        bit            fits;
        logic [63:0]   need;
        swr_pkg::res_t r;
        swr_pkg::res_t rel;
        locate(h, ws, sp, wc, off, fits);
        r = '0;
        r.kind = swr_pkg::KIND_VERDICT;
        r.last = 1'b1;
        if (rx_halted)
        begin
            // finished transfer: every header is dropped at slot 0
            due_events.push_back(r);
        end
        else
        begin
            if (fits)
            begin
                slot_present[off] = 1'b1;
                slot_len[off] = (h.payload_len > swr_pkg::MAX_PAYLOAD)
                                ? swr_pkg::MAX_PAYLOAD : h.payload_len;
                if (stored_total < 65535)
                    stored_total++;
            end
            // completion is tested on dropped headers too, and sticks
            if (stored_total == h.total_expected)
                xfer_done = 1'b1;
            r.accepted = fits;
            r.slot = (off < wc) ? swr_pkg::slot_t'(off) : '0;
            need = (64'd1 << wc) - 64'd1;
            if ((slot_present & need) != need)
            begin
                due_events.push_back(r);
            end
            else
            begin
                // full window: releases in slot order, then the ack carries the verdict
                for (int i = 0; i < wc; i++)
                begin
                    rel = '0;
                    rel.kind = swr_pkg::KIND_RELEASE;
                    rel.slot = swr_pkg::slot_t'(i);
                    rel.length = slot_len[i];
                    due_events.push_back(rel);
                end
                r.kind = swr_pkg::KIND_ACK;
                r.ack_seq = swr_pkg::seq_t'(base_seq + wc - 1);
                r.finished = xfer_done;
                due_events.push_back(r);
                windows_slid++;
                if (xfer_done)
                begin
                    rx_halted = 1'b1;
                end
                else
                begin
                    base_seq = base_seq + ws;
                    if (base_seq >= sp)
                        base_seq = 0;
                    slot_present = '0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Sends one header; the sender works in bursts and idles between them
    task automatic send_header(input swr_pkg::hdr_t h);
        int unsigned ws, sp, wc, off, gap, next_total;
        bit          fits;
        if (!finish_allowed)
        begin
            // keep the transfer from completing before the finish test
            locate(h, ws, sp, wc, off, fits);
            next_total = stored_total + ((fits && stored_total < 65535) ? 1 : 0);
            if (next_total == h.total_expected)
                h.total_expected = h.total_expected + 8'd1;
        end
        hdr_bus <= h;
        hdr_valid <= 1'b1;
        @(posedge clk);
        while (hdr_stall)
            @(posedge clk);
        judge_header(h);
        headers_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 6);
            hdr_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // Drops valid, lets every owed item drain, then lets the block settle
    task automatic wait_idle(input int unsigned settle);
        hdr_valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_register(input swr_pkg::cfg_idx_t idx,
                                  input logic [swr_pkg::CFG_W-1:0] value);
        wait_idle(SETTLE_CYCLES);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == swr_pkg::CFG_WINDOW_SIZE)
            ws_cfg = value[5:0];
        else
            space_cfg = value;
    endtask

    function automatic swr_pkg::hdr_t make_hdr(input int unsigned seq,
                                               input int unsigned count,
                                               input int unsigned len);
        swr_pkg::hdr_t h;
        h.seq_num = swr_pkg::seq_t'(seq);
        h.window_count = count[7:0];
        h.total_expected = 8'($urandom_range(0, 255));
        h.payload_len = swr_pkg::len_t'(len);
        return h;
    endfunction

    // A sequence number that lands on the given offset, often aliased by whole spaces
    function automatic swr_pkg::seq_t seq_for_offset(input int unsigned off);
        int unsigned sp, s, kmax;
        sp = effective_space();
        s = ((base_seq % sp) + off) % sp;
        kmax = (65535 - s) / sp;
        return swr_pkg::seq_t'(s + sp * (($urandom_range(0, 1) == 0) ? 0
                                                                      : $urandom_range(0, kmax)));
    endfunction

    // Keeps sending until the window slides: new slots in random order, with
    // duplicates and stray headers mixed in. Caller keeps width <= the space.
    task automatic fill_window(input int unsigned width);
        int unsigned   start, ws, off, roll;
        int unsigned   open_slots [$];
        int unsigned   held_slots [$];
        swr_pkg::hdr_t h;
        start = windows_slid;
        ws = effective_window();
        while (windows_slid == start)
        begin
            open_slots.delete();
            held_slots.delete();
            for (int i = 0; i < width; i++)
            begin
                if (slot_present[i])
                    held_slots.push_back(i);
                else
                    open_slots.push_back(i);
            end
            roll = $urandom_range(0, 99);
            h = make_hdr(0, width, 0);
            if (width == ws && $urandom_range(0, 2) == 0)
                h.window_count = 8'($urandom_range(ws, 255));  // clamps back to the window
            case ($urandom_range(0, 9))
                0:       h.payload_len = '0;
                1:       h.payload_len = '1;
                2:       h.payload_len = swr_pkg::MAX_PAYLOAD
                                         + swr_pkg::len_t'($urandom_range(0, 1));
                default: h.payload_len = swr_pkg::len_t'($urandom_range(0, 2047));
            endcase
            if (roll < 20)
            begin
                h.seq_num = swr_pkg::seq_t'($urandom);
                h.window_count = 8'($urandom);
            end
            else
            begin
                if (open_slots.size() == 0 || (roll < 35 && held_slots.size() != 0))
                    off = held_slots[$urandom_range(0, held_slots.size() - 1)];
                else
                    off = open_slots[$urandom_range(0, open_slots.size() - 1)];
                h.seq_num = seq_for_offset(off);
            end
            send_header(h);
        end
    endtask

    // Reset settings: window 35, space 340
    task automatic test_reset_settings();
        send_header(make_hdr(0, 0, 2047));         // count 0 acts as 1, release at once
        send_header(make_hdr(65535, 255, 0));      // far outside, count clamped
        send_header(make_hdr(35 + 340, 2, 1468));  // one space above base, slot 0
        send_header(make_hdr(35, 2, 5));           // same slot again, dropped
        send_header(make_hdr(36, 2, 100));         // fills the window of two
    endtask

    // Out-of-range and extreme register values, base left beyond a shrunk space
    task automatic test_register_limits();
        write_register(swr_pkg::CFG_WINDOW_SIZE, 16'd0);
        write_register(swr_pkg::CFG_SEQ_SPACE, 16'd0);
        send_header(make_hdr(1, 5, 7));
        send_header(make_hdr(65534, 0, 1469));
        write_register(swr_pkg::CFG_SEQ_SPACE, 16'd1);
        send_header(make_hdr(3, 1, 9));
        send_header(make_hdr(4, 1, 11));
        write_register(swr_pkg::CFG_WINDOW_SIZE, 16'd63);
        write_register(swr_pkg::CFG_SEQ_SPACE, 16'd65535);
        send_header(make_hdr(65534, 255, 2));
        send_header(make_hdr(1, 3, 1234));
        send_header(make_hdr(3, 3, 1024));
        send_header(make_hdr(2, 3, 512));
        write_register(swr_pkg::CFG_SEQ_SPACE, 16'd50);
        send_header(make_hdr(14, 1, 77));
    endtask

    // Phases of random windows under several settings
    task automatic test_random_windows();
        int unsigned ws, sp, max_w, start, width;
        bit          big_first;
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: begin ws = 35; sp = 340;   end
                1: begin ws = 63; sp = 65535; end
                2: begin ws = 7;  sp = 20;    end
                3: begin ws = 1;  sp = 2;     end
                4: begin ws = 12; sp = 100;   end
                5: begin ws = 40; sp = 37;    end  // space below the window: base resets
                default:
                begin
                    ws = $urandom_range(1, 63);
                    sp = $urandom_range(2, 65535);
                end
            endcase
            write_register(swr_pkg::CFG_WINDOW_SIZE, ws[swr_pkg::CFG_W-1:0]);
            write_register(swr_pkg::CFG_SEQ_SPACE, sp[swr_pkg::CFG_W-1:0]);
            max_w = effective_window();
            if (effective_space() < max_w)
                max_w = effective_space();
            big_first = (p == 1);
            start = headers_sent;
            while (headers_sent - start < PHASE_ITEMS && stored_total < STORE_STOP)
            begin
                if (big_first)
                    width = max_w;  // one window at the largest size: 63 slots
                else if ($urandom_range(0, 9) < 7)
                    width = $urandom_range(1, (max_w < 6) ? max_w : 6);
                else
                    width = $urandom_range(1, max_w);
                big_first = 1'b0;
                if (width > STORE_CAP - stored_total)
                    width = STORE_CAP - stored_total;
                fill_window(width);
            end
        end
    endtask

    // Completion set by a dropped header, then the final ack and halted behavior
    task automatic test_finish();
        swr_pkg::hdr_t h;
        write_register(swr_pkg::CFG_WINDOW_SIZE, 16'd3);
        write_register(swr_pkg::CFG_SEQ_SPACE, 16'd9);
        finish_allowed = 1'b1;
        h = make_hdr(seq_for_offset(5), 3, 200);
        h.total_expected = stored_total[7:0];
        send_header(h);
        fill_window(3);
        repeat (3)
            send_header(make_hdr($urandom, $urandom, $urandom_range(0, 2047)));
    endtask

    // Receiver stall: a new pattern each time the step counter wraps, one of them never stalls
    always @(posedge clk)
    begin
        stall_step <= stall_step + 7'd1;
        if (stall_step == '1)
            stall_mode <= rx_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            RX_FREE:  res_stall <= 1'b0;
            RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
            default:  res_stall <= (stall_step[2:0] < 3'd3);
        endcase
    end

    // Each result item is checked against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_events.size() == 0)
            begin
                report_mismatch("item with nothing owed, kind", res_bus.kind, 0);
            end
            else
            begin
                next_due = due_events.pop_front();
                if (res_bus.kind !== next_due.kind)
                    report_mismatch("kind", res_bus.kind, next_due.kind);
                if (res_bus.accepted !== next_due.accepted)
                    report_mismatch("accepted", res_bus.accepted, next_due.accepted);
                if (res_bus.slot !== next_due.slot)
                    report_mismatch("slot", res_bus.slot, next_due.slot);
                if (res_bus.length !== next_due.length)
                    report_mismatch("length", res_bus.length, next_due.length);
                if (res_bus.ack_seq !== next_due.ack_seq)
                    report_mismatch("ack_seq", res_bus.ack_seq, next_due.ack_seq);
                if (res_bus.finished !== next_due.finished)
                    report_mismatch("finished", res_bus.finished, next_due.finished);
                if (res_bus.last !== next_due.last)
                    report_mismatch("last", res_bus.last, next_due.last);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((hdr_valid && !hdr_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_register_limits();
        test_random_windows();
        test_finish();
        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
